// ===== design/bpl_pkg.sv =====
// package for the bitmap to position list block: constants, types and helper functions
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

	localparam int LEN_W                    = 17;
	localparam int DATA_W                   = 8;
	localparam int BIT_IDX_W                = 3;
	localparam int POS_EXT_W                = 24;
	localparam int DEFAULT_MAX_BITMAP_BYTES = 65536;

	// bitmap lengths in bytes that still fit a one or two byte run
	localparam logic [LEN_W-1:0] LEN_ONE_BYTE_MAX = LEN_W'(256 / 8);
	localparam logic [LEN_W-1:0] LEN_TWO_BYTE_MAX = LEN_W'(65536 / 8);

	// index of the byte still to be sent within a run, most significant first
	typedef logic [1:0] run_idx_t;

	localparam run_idx_t RUN_IDX_LOW  = 2'd0;
	localparam run_idx_t RUN_IDX_MID  = 2'd1;
	localparam run_idx_t RUN_IDX_HIGH = 2'd2;

	// run length minus one for a given bitmap length
	function automatic run_idx_t run_top_idx(input logic [LEN_W-1:0] len_bytes);
		run_idx_t r;
		if (len_bytes <= LEN_ONE_BYTE_MAX) begin
			r = RUN_IDX_LOW;
		end else if (len_bytes <= LEN_TWO_BYTE_MAX) begin
			r = RUN_IDX_MID;
		end else begin
			r = RUN_IDX_HIGH;
		end
		return r;
	endfunction

	// position of the lowest set bit, zero for an empty byte
	function automatic logic [BIT_IDX_W-1:0] lowest_set_bit(input logic [DATA_W-1:0] mask);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = BIT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== design/bpl_if.sv =====
// valid/ready channel interfaces for bitmap bytes in and position bytes out
`timescale 1ns / 1ps
`default_nettype none

interface bpl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] bitmap_byte;
	logic       last_byte;

	modport source (output valid, output bitmap_byte, output last_byte, input ready);
	modport sink (input valid, input bitmap_byte, input last_byte, output ready);
endinterface

interface bpl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       run_last;
	logic       from_final_input;

	modport source (output valid, output packed_byte, output run_last,
		output from_final_input, input ready);
	modport sink (input valid, input packed_byte, input run_last,
		input from_final_input, output ready);
endinterface

`default_nettype wire

// ===== design/bitmap_to_position_list_top.sv =====
// bitmap to position list: one bitmap byte per input transaction, set-bit positions out
//
// in_ch carries one bitmap byte per transaction plus a flag on the final byte.
// out_ch carries the positions of the set bits, byte index * 8 + bit number,
// lowest bit first, each as a big-endian run of 1, 2 or 3 bytes picked by
// cfg_wr_data (bitmap length in bytes, written with cfg_wr_en while idle).
// run_last marks the last output byte of an input byte, from_final_input copies
// the final flag. an empty byte gives no output and leaves the input stage
// empty, so empty bytes stream at one per cycle. a byte with n set bits and run
// length r is held in the input stage for n * r output bytes, one per cycle
// while the receiver does not stall; the next byte is taken in the cycle the last
// output byte moves to the output register. input bytes pass the input stage,
// then the output register. when the receiver stalls the output register holds
// and the input stage fills, then in_ch.ready drops. reset clears the byte index,
// sets the length register to 1 and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_to_position_list_top
	import bpl_pkg::*;
#(
	parameter int MAX_BITMAP_BYTES = DEFAULT_MAX_BITMAP_BYTES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [LEN_W-1:0] cfg_wr_data,
	bpl_in_if.sink                in_ch,
	bpl_out_if.source             out_ch
);

	localparam int POS_W = $clog2(MAX_BITMAP_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BITMAP_BYTES - 1);

	logic [LEN_W-1:0]  len_q;
	logic [POS_W-1:0]  byte_pos_q;

	logic              stage_valid_s1;
	logic [DATA_W-1:0] mask_s1;
	logic [POS_W-1:0]  byte_pos_s1;
	logic              final_s1;
	run_idx_t          run_idx_s1;

	logic              out_valid_s2;
	logic [DATA_W-1:0] packed_byte_s2;
	logic              run_last_s2;
	logic              final_s2;

	run_idx_t               run_top;
	logic [BIT_IDX_W-1:0]   bit_idx;
	logic [POS_EXT_W-1:0]   pos_ext;
	logic [DATA_W-1:0]      emit_byte;
	logic                   last_bit;
	logic                   advance;
	logic                   stage_done;
	logic                   in_acc;

	assign run_top    = run_top_idx(len_q);
	assign bit_idx    = lowest_set_bit(mask_s1);
	assign pos_ext    = POS_EXT_W'({byte_pos_s1, bit_idx});
	assign last_bit   = ((mask_s1 & (mask_s1 - DATA_W'(1))) == '0);
	assign advance    = stage_valid_s1 && (!out_valid_s2 || out_ch.ready);
	assign stage_done = advance && last_bit && (run_idx_s1 == RUN_IDX_LOW);
	assign in_acc     = in_ch.valid && in_ch.ready;

	assign in_ch.ready = !stage_valid_s1 || stage_done;

	always_comb begin
		case (run_idx_s1)
			RUN_IDX_LOW:  emit_byte = pos_ext[7:0];
			RUN_IDX_MID:  emit_byte = pos_ext[15:8];
			RUN_IDX_HIGH: emit_byte = pos_ext[23:16];
			default:      emit_byte = '0;
		endcase
	end

	// length register, zero behaves as one through the run length compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	// running byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
		end else if (in_acc) begin
			if (in_ch.last_byte || byte_pos_q == POS_LAST) begin
				byte_pos_q <= '0;
			end else begin
				byte_pos_q <= byte_pos_q + POS_W'(1);
			end
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			stage_valid_s1 <= (in_ch.bitmap_byte != '0);
		end else if (stage_done) begin
			stage_valid_s1 <= 1'b0;
		end
	end

	// input stage payload, walks bits and run bytes
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mask_s1     <= in_ch.bitmap_byte;
			byte_pos_s1 <= byte_pos_q;
			final_s1    <= in_ch.last_byte;
			run_idx_s1  <= run_top;
		end else if (advance) begin
			if (run_idx_s1 == RUN_IDX_LOW) begin
				mask_s1    <= mask_s1 & (mask_s1 - DATA_W'(1));
				run_idx_s1 <= run_top;
			end else begin
				run_idx_s1 <= run_idx_s1 - run_idx_t'(1);
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			packed_byte_s2 <= emit_byte;
			run_last_s2    <= last_bit && (run_idx_s1 == RUN_IDX_LOW);
			final_s2       <= final_s1;
		end
	end

	assign out_ch.valid            = out_valid_s2;
	assign out_ch.packed_byte      = packed_byte_s2;
	assign out_ch.run_last         = run_last_s2;
	assign out_ch.from_final_input = final_s2;

	// an occupied input stage always has a bit left to send
	a_stage_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_s1 |-> (mask_s1 != '0))
		else $error("input stage occupied with empty mask");

	// a new byte enters a busy stage only as the old one finishes
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && stage_valid_s1) |-> stage_done)
		else $error("input stage overwritten before done");

	// run byte index never exceeds the top index of the configured run length
	a_run_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_s1 |-> (run_idx_s1 <= run_top))
		else $error("run byte index out of range");

	// output register is loaded only when free or being drained
	a_out_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !out_ch.ready) |=> (out_valid_s2 && $stable(packed_byte_s2)))
		else $error("stalled output transaction lost");

endmodule

`default_nettype wire

// ===== bench/bitmap_to_position_list_top_tb.sv =====
// testbench for bitmap_to_position_list_top: directed and random bitmaps, scoreboard of set-bit positions
`timescale 1ns / 1ps

typedef struct packed {
	logic [7:0] packed_byte;
	logic       run_last;
	logic       from_final_input;
} pos_byte_t;

class position_scoreboard;
	logic [16:0] length_reg;
	logic [15:0] byte_index;
	pos_byte_t   pending_q[$];
	int          mismatches;

	function new();
		length_reg = 17'd1;
		byte_index = '0;
		mismatches = 0;
	endfunction

	function void write_length(logic [16:0] value);
		length_reg = value;
	endfunction

	function int run_bytes();
		if (length_reg <= 17'd32) begin
			return 1;
		end else if (length_reg <= 17'd8192) begin
			return 2;
		end
		return 3;
	endfunction

	function void note_bitmap_byte(logic [7:0] data, logic last);
		int          nb;
		int          total;
		int          idx;
		logic [23:0] pos;
		pos_byte_t   e;
		nb = run_bytes();
		total = $countones(data) * nb;
		idx = 0;
		for (int b = 0; b < 8; b++) begin
			if (data[b]) begin
				pos = {5'd0, byte_index, 3'(b)};
				for (int k = nb - 1; k >= 0; k--) begin
					e.packed_byte = pos[8*k +: 8];
					e.run_last = (idx == total - 1);
					e.from_final_input = last;
					pending_q.push_back(e);
					idx++;
				end
			end
		end
		// index wraps at the default bitmap size of 65536 bytes
		byte_index = last ? 16'd0 : byte_index + 16'd1;
	endfunction

	function void check_position_byte(pos_byte_t got);
		pos_byte_t want;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected transaction: packed_byte %h run_last %b from_final_input %b",
					got.packed_byte, got.run_last, got.from_final_input);
			end
			return;
		end
		want = pending_q.pop_front();
		if (got.packed_byte !== want.packed_byte || got.run_last !== want.run_last ||
			got.from_final_input !== want.from_final_input) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected packed_byte %h run_last %b from_final_input %b, got %h %b %b",
					want.packed_byte, want.run_last, want.from_final_input,
					got.packed_byte, got.run_last, got.from_final_input);
			end
		end
	endfunction
endclass

module bitmap_to_position_list_top_tb;
	import bpl_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;
	bit               in_idle_en;
	bit               out_idle_en;

	bpl_in_if  in_ch();
	bpl_out_if out_ch();

	position_scoreboard sb;

	bitmap_to_position_list_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	// output side: check each transaction, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_position_byte({out_ch.packed_byte, out_ch.run_last, out_ch.from_final_input});
		end
		out_ch.ready <= out_idle_en ? ($urandom_range(99) >= 10) : 1'b1;
	end

	task automatic send_byte(input logic [7:0] data, input logic last);
		if (in_idle_en && $urandom_range(99) < 10) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.bitmap_byte <= data;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_bitmap_byte(data, last);
	endtask

	task automatic drain_outputs();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		// empty bytes give no transaction, so allow the pipeline to empty
		repeat (8) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		drain_outputs();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_length(value);
	endtask

	function automatic logic [7:0] random_byte();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) begin
			return 8'h00;
		end else if (sel < 80) begin
			return 8'(1 << $urandom_range(7));
		end else if (sel < 93) begin
			return 8'($urandom);
		end
		return 8'hFF;
	endfunction

	task automatic send_bitmap(input int nbytes, input bit closed);
		for (int i = 0; i < nbytes; i++) begin
			send_byte(random_byte(), closed && (i == nbytes - 1));
		end
	endtask

	initial begin
		int lens[9];
		int count;
		int n;
		bit closed;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.bitmap_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte runs at the reset length
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h81, 1'b1);
		// zero length acts as one byte
		write_length('0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		write_length(LEN_W'(33));
		send_byte(8'hFF, 1'b0);
		send_byte(8'h10, 1'b1);
		write_length(LEN_W'(8193));
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
		write_length(LEN_W'(131071));
		send_byte(8'h01, 1'b1);

		lens = '{1, 0, 32, 33, 8192, 8193, 65536, 131071, 1};
		lens[8] = $urandom_range(1, 131071);
		for (int p = 0; p < 9; p++) begin
			write_length(LEN_W'(lens[p]));
			in_idle_en = (p != 3);
			out_idle_en = (p != 3);
			count = 0;
			while (count < 45) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 12);
				closed = ($urandom_range(9) != 0);
				send_bitmap(n, closed);
				count += n;
			end
		end

		drain_outputs();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/bpl_pkg.sv
design/bpl_if.sv
design/bitmap_to_position_list_top.sv
bench/bitmap_to_position_list_top_tb.sv
